>>> rtl/core/dominance_rank_2d_defines.svh
// ----------------------------------------------------------------------------
// dominance_rank_2d_defines.svh
// Assertion macros for the dominance rank RTL.
// ----------------------------------------------------------------------------
`ifndef DOMINANCE_RANK_2D_DEFINES_SVH
`define DOMINANCE_RANK_2D_DEFINES_SVH

// same-cycle implication, off during reset
`define DRK_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dominance rank check failed");

// next-cycle implication, off during reset
`define DRK_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dominance rank check failed");

`endif

>>> rtl/core/drk_pkg.sv
// ----------------------------------------------------------------------------
// drk_pkg
// Shared constants and types for the dominance rank block.
// ----------------------------------------------------------------------------
package drk_pkg;

	localparam int OUT_IDX_W  = 6;
	localparam int OUT_RANK_W = 6;
	localparam int OUT_DATA_W = 16;

	// qualifiers for one compare of the shared unit
	typedef struct packed {
		logic valid;   // compare slot carries a real point
		logic self;    // candidate is the point being ranked
		logic earlier; // candidate was loaded before the ranked point
	} cmp_tag_t;

endpackage

>>> rtl/core/drk_cmp.sv
// ----------------------------------------------------------------------------
// drk_cmp
// Shared dominance compare: flags a candidate counted toward a rank.
// ----------------------------------------------------------------------------
module drk_cmp #(
	parameter int COORD_BITS = 16
) (
	input  logic signed [COORD_BITS-1:0] qx,
	input  logic signed [COORD_BITS-1:0] qy,
	input  logic signed [COORD_BITS-1:0] px,
	input  logic signed [COORD_BITS-1:0] py,
	input  drk_pkg::cmp_tag_t            tag,
	output logic                         hit
);

	logic dom;
	logic same;

	assign dom  = (qx <= px) && (qy <= py);
	assign same = (qx == px) && (qy == py);
	// exact duplicates count only if loaded earlier
	assign hit  = tag.valid && !tag.self && dom && (!same || tag.earlier);

endmodule

>>> rtl/core/dominance_rank_2d.sv
// After the request with tlast, each rank steps through the fetch, latch,
// scan and emit states, and an output stall holds it in emit.
// Throughput: one point per cycle while loading; the single compare unit and
// the one-read-port point memory rank the points one at a time.
// Reset: arst_n clears state, point count and output valid; memory is not
// cleared, only entries below the point count are used.
// ----------------------------------------------------------------------------
// dominance_rank_2d
// Loads a set of signed 2-D points, then streams the dominance rank of each.
// ----------------------------------------------------------------------------
`include "dominance_rank_2d_defines.svh"

module dominance_rank_2d #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// x_coord, y_coord, zero fill
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]         s_tdata,
	// last_point
	input  logic                                      s_tlast,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// point_index, rank, zero fill
	output logic [drk_pkg::OUT_DATA_W-1:0]            m_tdata,
	// last_rank
	output logic                                      m_tlast
);

	localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int PT_W   = 2 * COORD_BITS;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FETCH,
		ST_LATCH,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t                         state_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [ADDR_W-1:0]              p_q;
	logic [CNT_W-1:0]               qi_q;
	logic [ADDR_W-1:0]              q_s1;
	logic [CNT_W-1:0]               rank_q;
	logic [PT_W-1:0]                pt_q;
	logic                           out_valid_q;
	logic                           out_last_q;
	logic [ADDR_W-1:0]              out_idx_q;
	logic [CNT_W-1:0]               out_rank_q;

	logic [PT_W-1:0]                mem_q [MAX_POINTS];
	logic [PT_W-1:0]                rdata_q;
	logic [ADDR_W-1:0]              rd_addr;
	logic                           wr_en;
	logic                           in_req;
	logic                           out_req;
	logic                           hit;
	drk_pkg::cmp_tag_t              tag;
	logic [CNT_W-1:0]               rank_sum;

	assign s_tready = (state_q == ST_LOAD);
	assign in_req   = s_tvalid && s_tready;
	assign out_req  = out_valid_q && m_tready;
	assign wr_en    = in_req && (cnt_q < CNT_W'(MAX_POINTS));

	always_comb begin
		unique case (state_q)
			ST_FETCH: rd_addr = p_q;
			ST_SCAN:  rd_addr = qi_q[ADDR_W-1:0];
			default:  rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[cnt_q[ADDR_W-1:0]] <= s_tdata[PT_W-1:0];
		end
		rdata_q <= mem_q[rd_addr];
	end

	assign tag.valid   = (state_q == ST_SCAN);
	assign tag.self    = (q_s1 == p_q);
	assign tag.earlier = (q_s1 < p_q);

	drk_cmp #(
		.COORD_BITS(COORD_BITS)
	) u_cmp (
		.qx (rdata_q[COORD_BITS-1:0]),
		.qy (rdata_q[PT_W-1:COORD_BITS]),
		.px (pt_q[COORD_BITS-1:0]),
		.py (pt_q[PT_W-1:COORD_BITS]),
		.tag(tag),
		.hit(hit)
	);

	assign rank_sum = rank_q + CNT_W'(hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_req) begin
						if (wr_en) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (s_tlast) begin
							p_q     <= '0;
							state_q <= ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_LATCH;
				end
				ST_LATCH: begin
					pt_q    <= rdata_q;
					rank_q  <= '0;
					q_s1    <= '0;
					qi_q    <= CNT_W'(1);
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (qi_q == cnt_q) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= p_q;
						out_rank_q  <= rank_sum;
						out_last_q  <= (CNT_W'(p_q) + 1'b1 == cnt_q);
						state_q     <= ST_EMIT;
					end else begin
						rank_q <= rank_sum;
						q_s1   <= qi_q[ADDR_W-1:0];
						qi_q   <= qi_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_req) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							p_q     <= p_q + 1'b1;
							state_q <= ST_FETCH;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {
		(drk_pkg::OUT_DATA_W - drk_pkg::OUT_IDX_W - drk_pkg::OUT_RANK_W)'(0),
		drk_pkg::OUT_RANK_W'(out_rank_q),
		drk_pkg::OUT_IDX_W'(out_idx_q)
	};

	`DRK_ASSERT_IMP(a_no_overlap, m_tvalid, !s_tready)
	`DRK_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_POINTS))
	`DRK_ASSERT_IMP(a_rank_bound, m_tvalid, out_rank_q < cnt_q)
	`DRK_ASSERT_NEXT(a_set_done, m_tvalid && m_tready && m_tlast, s_tready && cnt_q == '0)

endmodule

>>> tb/tb_dominance_rank_2d.sv
// ----------------------------------------------------------------------------
// tb_dominance_rank_2d
// Streams sets of signed 2-D points into the block and checks every rank
// against a pairwise-count predictor: directed corner sets first, then
// random sets with bursty requests and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_dominance_rank_2d;

	localparam int MAX_PTS    = 64;
	localparam int IDLE_LIMIT = 8000;
	localparam int HOLD_LEN   = 600;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               last;
		logic               drain; // wait for all ranks before offering
	} point_req_t;

	typedef struct packed {
		logic [5:0] idx;
		logic [5:0] rank;
		logic       last;
		logic [3:0] fill;
	} rank_res_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	// x_coord, y_coord
	logic [31:0]                   s_tdata = '0;
	// last_point
	logic                          s_tlast = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	// point_index, rank, zero fill
	logic [drk_pkg::OUT_DATA_W-1:0] m_tdata;
	// last_rank
	logic                          m_tlast;

	point_req_t         point_q[$];
	rank_res_t          rank_q[$];
	logic signed [15:0] set_x [MAX_PTS];
	logic signed [15:0] set_y [MAX_PTS];
	int unsigned        set_cnt = 0;
	int unsigned        ranks_due = 0;
	int unsigned        ranks_seen = 0;
	int unsigned        errors = 0;
	int unsigned        burst_left = 1;
	int unsigned        gap_left = 0;
	int unsigned        hold_left = 0;
	bit                 held = 1'b0;
	int unsigned        stall_mode = 0;
	int unsigned        stall_run = 0;
	int unsigned        rx_cyc = 0;
	int unsigned        idle_cyc = 0;
	int unsigned        n_items = 0;
	logic               offer;
	logic               rdy;

	dominance_rank_2d i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// store one accepted point; on the last one, predict every rank of the set
	task automatic load_point(point_req_t p);
		int unsigned k;
		int unsigned q;
		int unsigned r;
		rank_res_t   e;
		if (set_cnt < MAX_PTS) begin
			set_x[set_cnt] = p.x;
			set_y[set_cnt] = p.y;
			set_cnt++;
		end
		if (p.last) begin
			for (k = 0; k < set_cnt; k++) begin
				r = 0;
				for (q = 0; q < set_cnt; q++) begin
					if (q != k && set_x[q] <= set_x[k] && set_y[q] <= set_y[k]) begin
						if (!(set_x[q] == set_x[k] && set_y[q] == set_y[k]) || q < k)
							r++;
					end
				end
				e.idx  = k[5:0];
				e.rank = r[5:0];
				e.last = (k + 1 == set_cnt);
				e.fill = '0;
				rank_q.push_back(e);
			end
			ranks_due += set_cnt;
			set_cnt = 0;
		end
	endtask

	function automatic logic signed [15:0] pick_coord(int unsigned style);
		logic signed [15:0] v;
		case (style)
			0: v = 16'($signed($urandom_range(0, 7)) - 4);
			1: v = 16'($urandom);
			default: begin
				case ($urandom_range(0, 3))
					0: v = 16'sh8000;
					1: v = 16'sh7fff;
					2: v = -16'sd1;
					default: v = 16'sd0;
				endcase
			end
		endcase
		return v;
	endfunction

	task automatic add_point(logic signed [15:0] x, logic signed [15:0] y, logic last,
		logic drain);
		point_req_t p;
		p.x = x;
		p.y = y;
		p.last = last;
		p.drain = drain;
		point_q.push_back(p);
		n_items++;
	endtask

	task automatic add_set(int unsigned size);
		int unsigned style;
		int unsigned i;
		logic        drain;
		style = $urandom_range(0, 3);
		drain = ($urandom_range(0, 3) == 0);
		for (i = 0; i < size; i++)
			add_point(pick_coord(style == 3 ? $urandom_range(0, 2) : style),
				pick_coord(style == 3 ? $urandom_range(0, 2) : style),
				i + 1 == size, drain && i == 0);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
		end else begin
			offer = s_tvalid;
			if (s_tvalid && s_tready) begin
				load_point(point_q.pop_front());
				offer = 1'b0;
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (point_q.size() > 0 &&
					!(point_q[0].drain && ranks_seen != ranks_due)) begin
					offer = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
			s_tvalid <= offer;
			if (offer) begin
				s_tdata <= {point_q[0].y, point_q[0].x};
				s_tlast <= point_q[0].last;
			end
		end
	end

	// rank monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		rank_res_t got;
		rank_res_t want;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			ranks_seen <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.idx  = m_tdata[5:0];
				got.rank = m_tdata[11:6];
				got.last = m_tlast;
				got.fill = m_tdata[15:12];
				if (rank_q.size() == 0) begin
					$display("%0t unexpected rank: expected none, actual idx=%0d rank=%0d last=%0b",
						$realtime, got.idx, got.rank, got.last);
					errors++;
				end else begin
					want = rank_q.pop_front();
					if (got.idx != want.idx) begin
						$display("%0t point_index: expected %0d, actual %0d",
							$realtime, want.idx, got.idx);
						errors++;
					end
					if (got.rank != want.rank) begin
						$display("%0t rank of point %0d: expected %0d, actual %0d",
							$realtime, want.idx, want.rank, got.rank);
						errors++;
					end
					if (got.last != want.last) begin
						$display("%0t last_rank of point %0d: expected %0b, actual %0b",
							$realtime, want.idx, want.last, got.last);
						errors++;
					end
					if (got.fill != want.fill) begin
						$display("%0t tdata fill: expected %0h, actual %0h",
							$realtime, want.fill, got.fill);
						errors++;
					end
				end
				ranks_seen <= ranks_seen + 1;
				if (ranks_seen == 40 && !held) begin
					hold_left = HOLD_LEN;
					held = 1'b1;
				end
			end
			rx_cyc++;
			if (rx_cyc % 150 == 0)
				stall_mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				case (stall_mode)
					0: rdy = 1'b1;
					1: rdy = ($urandom_range(0, 9) > 2);
					2: rdy = ~m_tready;
					default: begin
						if (stall_run > 0) begin
							stall_run--;
							rdy = 1'b0;
						end else begin
							rdy = 1'b1;
							if ($urandom_range(0, 5) == 0)
								stall_run = $urandom_range(1, 10);
						end
					end
				endcase
			end
			m_tready <= rdy;
		end
	end

	// watchdog on cycles without any request or rank accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cyc = 0;
			end else begin
				idle_cyc++;
				if (idle_cyc >= IDLE_LIMIT) begin
					$display("dominance_rank_2d: mismatch");
					$finish;
				end
			end
		end
	end

	initial begin
		int unsigned r;

		// single extreme point
		add_point(16'sh8000, 16'sh8000, 1'b1, 1'b0);
		// extremes, equal-x ties, exact duplicates
		add_point(16'sh7fff, 16'sh7fff, 1'b0, 1'b1);
		add_point(16'sh8000, 16'sh7fff, 1'b0, 1'b0);
		add_point(16'sh7fff, 16'sh8000, 1'b0, 1'b0);
		add_point(16'sh8000, 16'sh8000, 1'b0, 1'b0);
		add_point(16'sd0, 16'sd0, 1'b0, 1'b0);
		add_point(16'sd0, 16'sd0, 1'b0, 1'b0);
		add_point(16'sd5, 16'sd3, 1'b0, 1'b0);
		add_point(16'sd5, 16'sd7, 1'b0, 1'b0);
		add_point(16'sd0, 16'sd0, 1'b0, 1'b0);
		add_point(-16'sd1, -16'sd1, 1'b0, 1'b0);
		add_point(16'sd5, 16'sd3, 1'b0, 1'b0);
		add_point(16'sh5555, 16'shaaaa, 1'b0, 1'b0);
		add_point(16'shaaaa, 16'sh5555, 1'b1, 1'b0);
		// all-equal set
		add_point(16'sd9, -16'sd9, 1'b0, 1'b1);
		add_point(16'sd9, -16'sd9, 1'b0, 1'b0);
		add_point(16'sd9, -16'sd9, 1'b1, 1'b0);

		// full set, then three past capacity so extra points get dropped
		add_set(MAX_PTS);
		add_set(MAX_PTS + 3);
		while (n_items < 450) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				add_set(MAX_PTS);
			else if (r == 1)
				add_set($urandom_range(MAX_PTS + 1, MAX_PTS + 4));
			else if (r < 5)
				add_set($urandom_range(11, 40));
			else
				add_set($urandom_range(1, 10));
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (point_q.size() != 0)
			@(posedge clk);
		while (ranks_seen != ranks_due)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (rank_q.size() != 0) begin
			$display("%0t ranks still expected: %0d, actual none", $realtime, rank_q.size());
			errors++;
		end
		if (errors == 0)
			$display("dominance_rank_2d: match");
		else
			$display("dominance_rank_2d: mismatch");
		$finish;
	end

endmodule
